// File: src/adaptive_threshold_calibrator_defines.svh
// Assertion macros for the adaptive threshold calibrator.
// Used by the top level only; the macros expect clk and rst_n in scope.
`ifndef ADAPTIVE_THRESHOLD_CALIBRATOR_DEFINES_SVH
`define ADAPTIVE_THRESHOLD_CALIBRATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/atc_pkg.sv
// Shared types and constants of the adaptive threshold calibrator.
// No dependencies; imported by the controller, the datapath and the top level.
package atc_pkg;

  localparam int PAIRS  = 16;
  localparam int PAIR_W = $clog2(PAIRS);
  localparam int CFG_AW = 4;

  localparam logic [1:0] REG_ALPHA     = 2'd0;
  localparam logic [1:0] REG_MIN_EVENT = 2'd1;
  localparam logic [1:0] REG_DEAD_BAND = 2'd2;

  localparam logic [15:0] ALPHA_RST     = 16'd13107;
  localparam logic [3:0]  MIN_EVENT_RST = 4'd5;
  localparam logic [15:0] DEAD_BAND_RST = 16'd9830;

  localparam logic       CMD_RECORD = 1'b0;
  localparam logic       CMD_RESET  = 1'b1;
  localparam logic [1:0] OC_FP      = 2'd1;
  localparam logic [1:0] OC_FN      = 2'd2;

  localparam logic signed [14:0] STEP_CONF    = 15'sd655;
  localparam logic signed [14:0] STEP_MARGIN  = 15'sd328;
  localparam logic signed [14:0] CONF_HI      = 15'sd6554;
  localparam logic signed [14:0] CONF_LO      = -15'sd3277;
  localparam logic signed [14:0] MARGIN_HI    = 15'sd5243;
  localparam logic signed [14:0] MARGIN_LO    = -15'sd655;
  localparam logic signed [13:0] CONF_CEIL    = 14'sd6488;
  localparam logic signed [13:0] MARGIN_CEIL  = 14'sd5177;
  localparam logic signed [17:0] EFF_CONF_LO  = 18'sd32768;
  localparam logic signed [17:0] EFF_CONF_HI  = 18'sd65208;
  localparam logic signed [17:0] EFF_MARG_LO  = 18'sd328;
  localparam logic signed [17:0] EFF_MARG_HI  = 18'sd16384;
  localparam logic [15:0]        DECAY_MUL    = 16'd45875;

  typedef struct packed {
    logic        command;
    logic [3:0]  pair_index;
    logic [1:0]  outcome;
    logic [15:0] factory_conf;
    logic [15:0] factory_margin;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  out_pair;
    logic [15:0] eff_conf;
    logic [15:0] eff_margin;
    logic        is_restore;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        fp_rate;
    logic [15:0]        fn_rate;
    logic [3:0]         batch_count;
    logic signed [13:0] conf_delta;
    logic signed [13:0] margin_delta;
    logic [15:0]        base_conf;
    logic [15:0]        base_mrg;
  } entry_t;

  typedef struct packed {
    logic [15:0] ewma_alpha;
    logic [3:0]  batch_min;
    logic [15:0] dead_band;
  } cfg_t;

  typedef struct packed {
    logic cap;
    logic scan_sel;
    logic idx_clr;
    logic idx_inc;
    logic ewma_en;
    logic adapt_en;
    logic fin_wr;
    logic out_load_upd;
    logic out_load_scan;
    logic clr_valid;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_reset;
    logic oor;
    logic emit;
    logic slot_free;
    logic scan_valid;
    logic scan_end;
  } dp_stat_t;

endpackage

// File: src/adaptive_threshold_calibrator.sv
// Top level of the adaptive threshold calibrator: configuration registers,
// controller and datapath. Depends on atc_pkg, atc_ctrl, atc_datapath and the defines header.
//
// The block takes one word at a time and accepts a new word whenever it is
// idle, even while a result word still waits in the output register. An
// outcome word occupies the block through these steps: the cycle in which it
// is accepted and registered, the table read, the two EWMA multipliers, the
// adaptation step, and the threshold clamp, ceiling decay and write-back. The
// next word is accepted only after the write-back, so the block takes no new
// outcome word before it is through with the last. The last step waits while
// an earlier result is still held, if this word produces a result. A reset
// word is registered and dispatched, then each pair in turn is read through
// the single read port of the table and, if valid, emitted as a restore word,
// plus any wait on the output. After reset the whole table is empty at once.
`include "adaptive_threshold_calibrator_defines.svh"

module adaptive_threshold_calibrator
  import atc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t        cfg_r;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;
  logic        cfg_wr;
  logic [1:0]  cfg_sel;
  logic        out_load;
  logic        in_acc;
  logic [3:0]  stage_act;
  logic        table_op;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ewma_alpha <= ALPHA_RST;
      cfg_r.batch_min  <= MIN_EVENT_RST;
      cfg_r.dead_band  <= DEAD_BAND_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ALPHA:     cfg_r.ewma_alpha <= pwdata[15:0];
        REG_MIN_EVENT: cfg_r.batch_min  <= pwdata[3:0];
        REG_DEAD_BAND: cfg_r.dead_band  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ALPHA:     prdata = {16'b0, cfg_r.ewma_alpha};
      REG_MIN_EVENT: prdata = {28'b0, cfg_r.batch_min};
      REG_DEAD_BAND: prdata = {16'b0, cfg_r.dead_band};
      default:       prdata = '0;
    endcase
  end

  atc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  atc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_load  = cmd.out_load_upd || cmd.out_load_scan;
  assign in_acc    = in_valid && !in_stall;
  assign stage_act = {cmd.ewma_en, cmd.adapt_en, cmd.fin_wr, cmd.out_load_scan};
  assign table_op  = cmd.fin_wr || cmd.out_load_scan || cmd.clr_valid;

  `ATC_ASSERT_NOW(a_load_free, out_load, stat.slot_free, "result loaded over a waiting word")
  `ATC_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "second word accepted while busy")
  `ATC_ASSERT_NOW(a_one_stage, 1'b1, $onehot0(stage_act), "datapath stages overlap")
  `ATC_ASSERT_NOW(a_idle_quiet, !in_stall, !table_op, "table touched while idle")

endmodule

// File: src/atc_ctrl.sv
// Sequencing state machine of the adaptive threshold calibrator.
// Depends on atc_pkg; drives the datapath through ctl_cmd_t and reads dp_stat_t.
module atc_ctrl
  import atc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RD        = 3'd1;
  localparam logic [2:0] ST_EWMA      = 3'd2;
  localparam logic [2:0] ST_ADAPT     = 3'd3;
  localparam logic [2:0] ST_FIN       = 3'd4;
  localparam logic [2:0] ST_SCAN_RD   = 3'd5;
  localparam logic [2:0] ST_SCAN_EMIT = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap  = in_valid;
        if (in_valid) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (stat.is_reset) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end else if (stat.oor) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EWMA;
        end
      end
      ST_EWMA: begin
        cmd.ewma_en = 1'b1;
        state_nxt   = ST_ADAPT;
      end
      ST_ADAPT: begin
        cmd.adapt_en = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.emit || stat.slot_free) begin
          cmd.fin_wr       = 1'b1;
          cmd.out_load_upd = stat.emit;
          state_nxt        = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        cmd.scan_sel = 1'b1;
        state_nxt    = ST_SCAN_EMIT;
      end
      ST_SCAN_EMIT: begin
        cmd.scan_sel = 1'b1;
        if (!stat.scan_valid || stat.slot_free) begin
          cmd.out_load_scan = stat.scan_valid;
          if (stat.scan_end) begin
            cmd.clr_valid = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_SCAN_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/atc_datapath.sv
// Datapath of the adaptive threshold calibrator: calibration table, EWMA and
// adaptation arithmetic, and the output word register. Depends on atc_pkg.
module atc_datapath
  import atc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_word_t  in_word,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  entry_t              mem_r [PAIRS];
  entry_t              rd_r;
  entry_t              ent_r;
  entry_t              ent_eff;
  entry_t              wdata;
  in_word_t            item_r;
  logic [PAIRS-1:0]    valid_r;
  logic [PAIR_W-1:0]   idx_r;
  logic [PAIR_W-1:0]   pair_addr;
  logic [PAIR_W-1:0]   rd_addr;
  logic [15:0]         fpn_r, fnn_r;
  logic [3:0]          bc_r;
  logic signed [13:0]  cd_r, md_r;
  logic                emit_r, tight_r;
  out_word_t           out_r;
  logic                out_valid_r;

  logic [15:0]         fp_ewma, fn_ewma;
  logic [3:0]          bc_inc;
  logic signed [16:0]  press;
  logic [16:0]         mag;
  logic                tight;
  logic signed [14:0]  cd_sum, md_sum;
  logic signed [17:0]  ec_sum, em_sum, ec_cl, em_cl;
  logic [32:0]         decay_acc;
  logic                decay;
  logic [PAIRS-1:0]    above;
  logic                slot_free;

  function automatic logic [15:0] ewma(input logic [15:0] alpha, input logic [15:0] old,
                                       input logic active);
    logic [16:0] inv;
    logic [33:0] acc;
    logic [17:0] res;
    inv = 17'h10000 - {1'b0, alpha};
    acc = 34'(inv * old) + 34'd32768;
    if (active) begin
      acc = acc + {2'b0, alpha, 16'b0} - {18'b0, alpha};
    end
    res = acc[33:16];
    return (res > 18'd65535) ? 16'hFFFF : res[15:0];
  endfunction

  function automatic logic signed [17:0] clamp18(input logic signed [17:0] v,
                                                 input logic signed [17:0] lo,
                                                 input logic signed [17:0] hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic logic signed [14:0] clamp15(input logic signed [14:0] v,
                                                 input logic signed [14:0] lo,
                                                 input logic signed [14:0] hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  assign pair_addr = PAIR_W'(item_r.pair_index);
  assign rd_addr   = cmd.scan_sel ? idx_r : pair_addr;

  // An entry without its valid bit reads as cleared, with the factory baseline.
  always_comb begin
    ent_eff = rd_r;
    if (!valid_r[pair_addr]) begin
      ent_eff           = '0;
      ent_eff.base_conf = item_r.factory_conf;
      ent_eff.base_mrg  = item_r.factory_margin;
    end
  end

  assign fp_ewma = ewma(cfg.ewma_alpha, ent_eff.fp_rate, item_r.outcome == OC_FP);
  assign fn_ewma = ewma(cfg.ewma_alpha, ent_eff.fn_rate, item_r.outcome == OC_FN);

  assign bc_inc = (ent_r.batch_count == 4'hF) ? 4'hF : ent_r.batch_count + 4'd1;
  assign press  = $signed({1'b0, fpn_r}) - $signed({1'b0, fnn_r});
  assign mag    = press[16] ? 17'(-press) : 17'(press);
  assign tight  = !press[16] && (press != 17'sd0);
  assign cd_sum = $signed({ent_r.conf_delta[13], ent_r.conf_delta})
                + (tight ? STEP_CONF : -STEP_CONF);
  assign md_sum = $signed({ent_r.margin_delta[13], ent_r.margin_delta})
                + (tight ? STEP_MARGIN : -STEP_MARGIN);

  assign ec_sum = $signed({2'b0, ent_r.base_conf}) + $signed({{4{cd_r[13]}}, cd_r});
  assign em_sum = $signed({2'b0, ent_r.base_mrg}) + $signed({{4{md_r[13]}}, md_r});
  assign ec_cl  = clamp18(ec_sum, EFF_CONF_LO, EFF_CONF_HI);
  assign em_cl  = clamp18(em_sum, EFF_MARG_LO, EFF_MARG_HI);

  assign decay_acc = 33'(fpn_r * DECAY_MUL) + 33'd32768;
  assign decay     = emit_r && tight_r && ((cd_r >= CONF_CEIL) || (md_r >= MARGIN_CEIL));

  always_comb begin
    wdata              = ent_r;
    wdata.fp_rate      = decay ? decay_acc[31:16] : fpn_r;
    wdata.fn_rate      = fnn_r;
    wdata.batch_count  = bc_r;
    wdata.conf_delta   = cd_r;
    wdata.margin_delta = md_r;
  end

  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      above[i] = (i > int'(idx_r));
    end
  end

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.fin_wr) begin
      mem_r[pair_addr] <= wdata;
    end
    rd_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_r <= in_word;
    end
    if (cmd.ewma_en) begin
      ent_r <= ent_eff;
      fpn_r <= fp_ewma;
      fnn_r <= fn_ewma;
    end
    if (cmd.adapt_en) begin
      cd_r    <= ent_r.conf_delta;
      md_r    <= ent_r.margin_delta;
      tight_r <= tight;
      if (bc_inc < cfg.batch_min) begin
        bc_r   <= bc_inc;
        emit_r <= 1'b0;
      end else if (mag < {1'b0, cfg.dead_band}) begin
        bc_r   <= 4'd0;
        emit_r <= 1'b0;
      end else begin
        bc_r   <= 4'd0;
        emit_r <= 1'b1;
        cd_r   <= 14'(clamp15(cd_sum, CONF_LO, CONF_HI));
        md_r   <= 14'(clamp15(md_sum, MARGIN_LO, MARGIN_HI));
      end
    end
    if (cmd.out_load_upd) begin
      out_r.out_pair   <= item_r.pair_index;
      out_r.eff_conf   <= ec_cl[15:0];
      out_r.eff_margin <= em_cl[15:0];
      out_r.is_restore <= 1'b0;
      out_r.last       <= 1'b0;
    end else if (cmd.out_load_scan) begin
      out_r.out_pair   <= 4'(idx_r);
      out_r.eff_conf   <= rd_r.base_conf;
      out_r.eff_margin <= rd_r.base_mrg;
      out_r.is_restore <= 1'b1;
      out_r.last       <= !(|(valid_r & above));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_valid) begin
        valid_r <= '0;
      end else if (cmd.fin_wr) begin
        valid_r[pair_addr] <= 1'b1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.out_load_upd || cmd.out_load_scan) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.is_reset   = (item_r.command == CMD_RESET);
  assign stat.oor        = (int'(item_r.pair_index) >= PAIRS);
  assign stat.emit       = emit_r;
  assign stat.slot_free  = slot_free;
  assign stat.scan_valid = valid_r[idx_r];
  assign stat.scan_end   = (idx_r == PAIR_W'(PAIRS - 1));

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
